/* rtl/core/ccem_pkg.sv */
// Shared types and constants for the core-count to enable-mask selector.
`default_nettype none

package ccem_pkg;

	// Mask and count widths
	localparam int MaskBits  = 64;
	localparam int CountW    = 7;
	localparam int ByteCnt   = MaskBits / 8;
	localparam int InTdataW  = 72;
	localparam int OutTdataW = 80;

	// Register map: byte address is 8 * index
	localparam logic [1:0] RegPresent  = 2'd0;
	localparam logic [1:0] RegFeature  = 2'd1;
	localparam logic [1:0] RegHotplug  = 2'd2;
	localparam logic [1:0] RegGameMode = 2'd3;

	// Result status codes
	typedef enum logic [1:0] {
		StOk       = 2'd0,
		StHotplug  = 2'd1,
		StGame     = 2'd2,
		StDisabled = 2'd3
	} status_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [MaskBits-1:0] present;
		logic                feature;
		logic                hotplug;
		logic                game;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/core/ccem_cfg.sv */
// APB configuration registers of the core-count to enable-mask selector.
`default_nettype none

module ccem_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [63:0]         pwdata,
	output logic      [63:0]         prdata,
	output logic                     pready,
	output ccem_pkg::cfg_t           cfg
);

	logic [ccem_pkg::MaskBits-1:0] present_q;
	logic                          feature_q;
	logic                          hotplug_q;
	logic                          game_q;
	logic                          wr_en;
	logic [1:0]                    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:3];

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			feature_q <= 1'b0;
			hotplug_q <= 1'b0;
			game_q    <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				ccem_pkg::RegPresent:  present_q <= pwdata[ccem_pkg::MaskBits-1:0];
				ccem_pkg::RegFeature:  feature_q <= pwdata[0];
				ccem_pkg::RegHotplug:  hotplug_q <= pwdata[0];
				ccem_pkg::RegGameMode: game_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (reg_idx)
			ccem_pkg::RegPresent:  prdata[ccem_pkg::MaskBits-1:0] = present_q;
			ccem_pkg::RegFeature:  prdata[0] = feature_q;
			ccem_pkg::RegHotplug:  prdata[0] = hotplug_q;
			ccem_pkg::RegGameMode: prdata[0] = game_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.present = present_q;
	assign cfg.feature = feature_q;
	assign cfg.hotplug = hotplug_q;
	assign cfg.game    = game_q;

endmodule

`default_nettype wire

/* rtl/core/ccem_pipe.sv */
// Four-stage datapath: local counts, byte prefix sums, selection, compare.
`default_nettype none

module ccem_pipe (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ccem_pkg::cfg_t                      cfg,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [ccem_pkg::CountW-1:0]         in_count,
	input  wire logic [ccem_pkg::MaskBits-1:0]       in_current,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output ccem_pkg::status_t                        out_status,
	output logic      [ccem_pkg::MaskBits-1:0]       out_desired,
	output logic                                     out_update,
	output logic      [ccem_pkg::CountW-1:0]         out_pcount
);

	localparam int MB = ccem_pkg::MaskBits;
	localparam int CW = ccem_pkg::CountW;
	localparam int NB = ccem_pkg::ByteCnt;

	// Valid bits and stage advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Stage 1: in-byte prefix counts, byte counts, status
	logic [2:0]        lpfx_c [MB];
	logic [3:0]        bcnt_c [NB];
	ccem_pkg::status_t st_c;

	always_comb begin
		for (int b = 0; b < NB; b++) begin
			logic [3:0] acc;
			acc = '0;
			for (int k = 0; k < 8; k++) begin
				lpfx_c[b*8+k] = acc[2:0];
				acc = acc + {3'd0, cfg.present[b*8+k]};
			end
			bcnt_c[b] = acc;
		end
	end

	always_comb begin
		if (cfg.hotplug)
			st_c = ccem_pkg::StHotplug;
		else if (cfg.game)
			st_c = ccem_pkg::StGame;
		else if (!cfg.feature || cfg.present == '0)
			st_c = ccem_pkg::StDisabled;
		else
			st_c = ccem_pkg::StOk;
	end

	logic [2:0]        lpfx_s1 [MB];
	logic [3:0]        bcnt_s1 [NB];
	ccem_pkg::status_t st_s1;
	logic [CW-1:0]     req_s1;
	logic [MB-1:0]     cur_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			lpfx_s1 <= lpfx_c;
			bcnt_s1 <= bcnt_c;
			st_s1   <= st_c;
			req_s1  <= in_count;
			cur_s1  <= in_current;
		end
	end

	// Stage 2: exclusive prefix over byte counts, total count
	logic [CW-1:0] base_c [NB];
	logic [CW-1:0] total_c;

	always_comb begin
		logic [CW-1:0] acc;
		acc = '0;
		for (int b = 0; b < NB; b++) begin
			base_c[b] = acc;
			acc = acc + {3'd0, bcnt_s1[b]};
		end
		total_c = acc;
	end

	logic [2:0]        lpfx_s2 [MB];
	logic [CW-1:0]     base_s2 [NB];
	logic [CW-1:0]     pcnt_s2;
	ccem_pkg::status_t st_s2;
	logic [CW-1:0]     req_s2;
	logic [MB-1:0]     cur_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			lpfx_s2 <= lpfx_s1;
			base_s2 <= base_c;
			pcnt_s2 <= total_c;
			st_s2   <= st_s1;
			req_s2  <= req_s1;
			cur_s2  <= cur_s1;
		end
	end

	// Stage 3: keep present bits whose rank is below the request
	logic [MB-1:0] sel_c;
	logic [MB-1:0] des_c;
	logic          full_c;

	always_comb begin
		for (int i = 0; i < MB; i++) begin
			logic [CW-1:0] rank;
			rank = base_s2[i/8] + {4'd0, lpfx_s2[i]};
			sel_c[i] = cfg.present[i] && (rank < req_s2);
		end
	end

	assign full_c = (req_s2 == '0) || (req_s2 > pcnt_s2);

	always_comb begin
		if (st_s2 != ccem_pkg::StOk)
			des_c = '0;
		else if (full_c)
			des_c = cfg.present;
		else
			des_c = sel_c;
	end

	logic [MB-1:0]     des_s3;
	logic [CW-1:0]     pcnt_s3;
	ccem_pkg::status_t st_s3;
	logic [MB-1:0]     cur_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			des_s3  <= des_c;
			pcnt_s3 <= pcnt_s2;
			st_s3   <= st_s2;
			cur_s3  <= cur_s2;
		end
	end

	// Stage 4: compare against the applied mask; output register
	logic [MB-1:0]     des_s4;
	logic [CW-1:0]     pcnt_s4;
	ccem_pkg::status_t st_s4;
	logic              upd_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			des_s4  <= des_s3;
			pcnt_s4 <= pcnt_s3;
			st_s4   <= st_s3;
			upd_s4  <= (st_s3 == ccem_pkg::StOk) && (des_s3 != cur_s3);
		end
	end

	assign out_valid   = v_s4;
	assign out_status  = st_s4;
	assign out_desired = des_s4;
	assign out_update  = upd_s4;
	assign out_pcount  = pcnt_s4;

endmodule

`default_nettype wire

/* rtl/core/core_count_to_enable_mask_core.sv */
// Top level of the core-count to enable-mask selector.
`default_nettype none

// Each request carries a core count and the mask now applied; the block returns
// the mask of the lowest N present cores (all present cores when N is zero or
// exceeds the present count, none when refused), a status, the present-core count
// and whether the applied mask must change. One request is accepted per clock
// unless back-pressure from the result stream has filled the datapath; each passes
// the four register stages (in-byte counts, byte prefix sums, rank selection,
// mask compare). Program the registers over APB only while no request is in flight.
module core_count_to_enable_mask_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	// Request stream
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [ccem_pkg::InTdataW-1:0]   s_axis_tdata,  // req_count[6:0],
	                                                            // current_mask[70:7]
	// Result stream
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic      [ccem_pkg::OutTdataW-1:0]  m_axis_tdata   // status[1:0],
	                                                            // desired_mask[65:2],
	                                                            // update_needed[66],
	                                                            // present_count[73:67]
);

	ccem_pkg::cfg_t    cfg;
	ccem_pkg::status_t status;
	logic [63:0]       desired_mask;
	logic              update_needed;
	logic [6:0]        present_count;

	ccem_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ccem_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_count    (s_axis_tdata[6:0]),
		.in_current  (s_axis_tdata[70:7]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (status),
		.out_desired (desired_mask),
		.out_update  (update_needed),
		.out_pcount  (present_count)
	);

	// Pack result transaction
	assign m_axis_tdata = {6'd0, present_count, update_needed, desired_mask, status};

	// A refused request never selects cores
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status != ccem_pkg::StOk) |-> (desired_mask == '0))
		else $error("refused request carries a nonzero mask");

	// An update is only flagged for an accepted request
	a_update_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && update_needed) |-> (status == ccem_pkg::StOk))
		else $error("update flagged on refused request");

	// The output register holds a waiting result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("waiting result changed");

endmodule

`default_nettype wire
